[rtl/core/ssep_pkg.sv]
// Shared types, constants and helpers for the separator-based string splitter.
`default_nettype none

package ssep_pkg;

    localparam int MAX_SEP_BYTES = 8;
    localparam int BYTE_W        = 8;
    localparam int SEP_W         = MAX_SEP_BYTES * BYTE_W;
    localparam int LEN_W         = 4;
    localparam int POS_W         = (MAX_SEP_BYTES > 1) ? $clog2(MAX_SEP_BYTES) : 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEP_BYTES = 2'd0,
        CFG_SEP_LEN   = 2'd1
    } t_cfg_idx;

    // One queued input word
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              last;
    } t_item;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              chunk_end;
        logic              string_end;
    } t_result;

    // Separator settings as seen by the back end
    typedef struct packed {
        logic [SEP_W-1:0] sep;
        logic [LEN_W-1:0] len;
    } t_sep_cfg;

    // Clamp the programmed length into 1..MAX_SEP_BYTES
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] res;
        if (raw == '0) begin
            res = LEN_W'(1);
        end else if (raw > LEN_W'(MAX_SEP_BYTES)) begin
            res = LEN_W'(MAX_SEP_BYTES);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ssep_if.sv]
// Channel interfaces of the splitter: input words, result words and configuration writes.
`default_nettype none

interface ssep_in_if import ssep_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              has_byte;
    logic              is_last;

    modport source (output valid, output in_byte, output has_byte, output is_last,
                    input ready);
    modport sink   (input valid, input in_byte, input has_byte, input is_last,
                    output ready);
endinterface

interface ssep_out_if import ssep_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              chunk_end;
    logic              string_end;

    modport source (output valid, output out_byte, output byte_valid, output chunk_end,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input chunk_end,
                    input string_end, output ready);
endinterface

interface ssep_cfg_if import ssep_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/string_split_by_separator_unit.sv]
// Top level of the splitter: configuration registers and the front, queue and back ends.
//
// Usage:
//   i_in carries the string one word at a time: in_byte with has_byte, and is_last on the
//   final word. A word with neither has_byte nor is_last is taken and causes nothing.
//   o_out returns result words: chunk bytes (byte_valid), chunk ends (chunk_end) and, on the
//   last word of each string, string_end together with chunk_end.
//   i_cfg writes the separator bytes (index 0, first byte in bits 7:0) and the separator
//   length (index 1, clamped to 1..8). It is always ready; write it only while idle.
// Timing:
//   A word's first result reaches o_out by way of the input queue and then the back
//   end's output register.
//   While o_out.ready stays high the back end issues one result word per cycle and takes
//   one input word per cycle, so a string streams at one byte per cycle. After an end mark
//   it issues one word per held byte (up to seven) plus the closing word before it takes
//   the next word, which also waits while the window holds the separator length or more.
// Reset and stalls:
//   Reset empties the queue and the window and sets the separator to one zero byte.
//   When the receiver holds o_out.ready low the result word is kept, the back end stops,
//   and i_in.ready falls once the four-word queue is full.
`default_nettype none

module string_split_by_separator_unit import ssep_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ssep_in_if.sink     i_in,
    ssep_out_if.source  o_out,
    ssep_cfg_if.sink    i_cfg
);

    logic [SEP_W-1:0] r_sep_bytes;
    logic [LEN_W-1:0] r_sep_len;
    t_sep_cfg         w_sep_cfg;

    logic             w_push;
    t_item            w_push_item;
    logic             w_full;
    logic             w_pop;
    logic             w_pop_valid;
    t_item            w_pop_item;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_bytes <= '0;
            r_sep_len   <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEP_BYTES: r_sep_bytes <= i_cfg.data[SEP_W-1:0];
                CFG_SEP_LEN:   r_sep_len   <= i_cfg.data[LEN_W-1:0];
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Hand the back end an already clamped length
    assign w_sep_cfg.sep = r_sep_bytes;
    assign w_sep_cfg.len = eff_len(r_sep_len);

    ssep_front u_front (
        .i_in        (i_in),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    ssep_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_valid (w_pop_valid),
        .o_pop_item  (w_pop_item)
    );

    ssep_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_sep_cfg),
        .i_q_valid (w_pop_valid),
        .i_q_item  (w_pop_item),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

[rtl/core/ssep_queue.sv]
// Small FIFO of input words between the front end and the back end.
`default_nettype none

module ssep_queue import ssep_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_push_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_pop_valid,
    output t_item      o_pop_item
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr, n_wptr;
    logic [Q_AW-1:0]  r_rptr, n_rptr;
    logic [Q_AW:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full      = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_item  = r_mem[r_rptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_pop_valid;

    always_comb begin
        n_wptr  = w_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = w_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ssep_front.sv]
// Front end: accept input words, drop words with neither byte nor end mark, queue the rest.
`default_nettype none

module ssep_front import ssep_pkg::*; (
    ssep_in_if.sink i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_item     o_push_item
);

    logic w_keep;

    // Accept whenever the queue has room
    assign i_in.ready = !i_full;

    // A word with no byte and no end mark causes nothing: drop it here
    assign w_keep = i_in.has_byte || i_in.is_last;
    assign o_push = i_in.valid && !i_full && w_keep;

    assign o_push_item.data = i_in.in_byte;
    assign o_push_item.has  = i_in.has_byte;
    assign o_push_item.last = i_in.is_last;

endmodule

`default_nettype wire

[rtl/core/ssep_back.sv]
// Back end: hold the pending window, match the separator and issue result words.
`default_nettype none

module ssep_back import ssep_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_sep_cfg i_cfg,
    input  wire logic     i_q_valid,
    input  wire t_item    i_q_item,
    output logic          o_q_pop,
    ssep_out_if.source    o_out
);

    logic [BYTE_W-1:0] r_win [MAX_SEP_BYTES];
    logic [BYTE_W-1:0] n_win [MAX_SEP_BYTES];
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_flush, n_flush;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [BYTE_W-1:0] w_win [MAX_SEP_BYTES];
    logic [LEN_W-1:0]  w_cnt;
    logic [LEN_W-1:0]  w_drop;
    logic [POS_W-1:0]  w_src;
    logic              w_match;
    logic              w_emit;
    logic              w_can_load;
    logic              w_pop;

    assign w_can_load = !r_out_valid || o_out.ready;
    // Pop only while the window is below the separator length and no flush runs
    assign w_pop      = w_can_load && (r_cnt < i_cfg.len) && !r_flush && i_q_valid;
    assign o_q_pop    = w_pop;

    always_comb begin
        w_win = r_win;
        w_cnt = r_cnt;
        if (w_pop && i_q_item.has) begin
            w_win[r_cnt[POS_W-1:0]] = i_q_item.data;
            w_cnt = r_cnt + 1'b1;
        end

        w_match = 1'b1;
        for (int k = 0; k < MAX_SEP_BYTES; k++) begin
            if ((LEN_W'(k) < i_cfg.len) && (w_win[k] != i_cfg.sep[k*BYTE_W +: BYTE_W])) begin
                w_match = 1'b0;
            end
        end

        w_drop  = '0;
        w_emit  = 1'b0;
        n_out   = r_out;
        n_flush = r_flush;
        if (w_can_load) begin
            if (w_cnt >= i_cfg.len) begin
                w_emit = 1'b1;
                if (w_match) begin
                    n_out  = '{out_byte: '0, byte_valid: 1'b0, chunk_end: 1'b1,
                               string_end: 1'b0};
                    w_drop = i_cfg.len;
                end else begin
                    n_out  = '{out_byte: w_win[0], byte_valid: 1'b1, chunk_end: 1'b0,
                               string_end: 1'b0};
                    w_drop = LEN_W'(1);
                end
            end else if (r_flush) begin
                w_emit = 1'b1;
                if (w_cnt != '0) begin
                    n_out  = '{out_byte: w_win[0], byte_valid: 1'b1, chunk_end: 1'b0,
                               string_end: 1'b0};
                    w_drop = LEN_W'(1);
                end else begin
                    n_out   = '{out_byte: '0, byte_valid: 1'b0, chunk_end: 1'b1,
                                string_end: 1'b1};
                    n_flush = 1'b0;
                end
            end
            if (w_pop && i_q_item.last) begin
                n_flush = 1'b1;
            end
        end

        w_src = '0;
        for (int i = 0; i < MAX_SEP_BYTES; i++) begin
            w_src = POS_W'(i + int'(w_drop));
            if (i + int'(w_drop) < MAX_SEP_BYTES) begin
                n_win[i] = w_win[w_src];
            end else begin
                n_win[i] = '0;
            end
        end
        n_cnt = w_cnt - w_drop;

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_out <= n_out;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out.out_byte;
    assign o_out.byte_valid = r_out.byte_valid;
    assign o_out.chunk_end  = r_out.chunk_end;
    assign o_out.string_end = r_out.string_end;

endmodule

`default_nettype wire

[verif/string_split_by_separator_unit_chk.sv]
`timescale 1ns / 1ps
// Splitter checker: predicts result words from accepted input words and compares them.
module string_split_by_separator_unit_chk import ssep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ssep_in_if   i_in_mon,
    ssep_out_if  i_out_mon,
    ssep_cfg_if  i_cfg_mon,
    output int   o_fail_cnt,
    output int   o_pending
);

    localparam int MAX_WORDS_PER_ITEM = MAX_SEP_BYTES + 1;

    logic [BYTE_W-1:0] held_bytes [MAX_SEP_BYTES];
    int unsigned       held_cnt;
    logic [SEP_W-1:0]  sep_bytes;
    logic [LEN_W-1:0]  sep_len;
    t_result           chunk_words_due [$];
    int                fails;

    function automatic void queue_word(logic [BYTE_W-1:0] b, logic bv, logic ce, logic se);
        t_result w;
        w.out_byte   = b;
        w.byte_valid = bv;
        w.chunk_end  = ce;
        w.string_end = se;
        chunk_words_due.push_back(w);
    endfunction

    // Drop n held bytes from the front and fill the tail with zeros
    function automatic void drop_held(int unsigned n);
        for (int i = 0; i < MAX_SEP_BYTES; i++) begin
            held_bytes[i] = (i + n < MAX_SEP_BYTES) ? held_bytes[i + n] : '0;
        end
        held_cnt = (n >= held_cnt) ? 0 : held_cnt - n;
    endfunction

    function automatic void split_word(logic [BYTE_W-1:0] b, logic has, logic last);
        int unsigned len;
        int          n;
        logic        hit;
        len = (sep_len == '0) ? 1 :
              (sep_len > LEN_W'(MAX_SEP_BYTES)) ? MAX_SEP_BYTES : int'(sep_len);
        n = 0;
        if (has && held_cnt < MAX_SEP_BYTES) begin
            held_bytes[held_cnt] = b;
            held_cnt++;
        end
        while (held_cnt >= len && n < MAX_WORDS_PER_ITEM) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (held_bytes[k] != sep_bytes[BYTE_W*k +: BYTE_W]) hit = 1'b0;
            end
            if (hit) begin
                queue_word('0, 1'b0, 1'b1, 1'b0);
                drop_held(len);
            end else begin
                queue_word(held_bytes[0], 1'b1, 1'b0, 1'b0);
                drop_held(1);
            end
            n++;
        end
        if (last) begin
            // flush the held bytes, then close the final chunk
            for (int i = 0; i < held_cnt && n < MAX_SEP_BYTES; i++) begin
                queue_word(held_bytes[i], 1'b1, 1'b0, 1'b0);
                n++;
            end
            queue_word('0, 1'b0, 1'b1, 1'b1);
            held_bytes = '{default: '0};
            held_cnt   = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                        logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held_bytes = '{default: '0};
            held_cnt   = 0;
            sep_bytes  = '0;
            sep_len    = LEN_W'(1);
            chunk_words_due.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                if (i_cfg_mon.index == CFG_SEP_BYTES) sep_bytes = i_cfg_mon.data;
                else if (i_cfg_mon.index == CFG_SEP_LEN) sep_len = i_cfg_mon.data[LEN_W-1:0];
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                split_word(i_in_mon.in_byte, i_in_mon.has_byte, i_in_mon.is_last);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (chunk_words_due.size() == 0) begin
                    $error("result word with nothing expected: byte %0h bv %0b ce %0b se %0b",
                           i_out_mon.out_byte, i_out_mon.byte_valid,
                           i_out_mon.chunk_end, i_out_mon.string_end);
                    fails++;
                end else begin
                    want = chunk_words_due.pop_front();
                    check_field("out_byte", want.out_byte, i_out_mon.out_byte);
                    check_field("byte_valid", BYTE_W'(want.byte_valid),
                                BYTE_W'(i_out_mon.byte_valid));
                    check_field("chunk_end", BYTE_W'(want.chunk_end),
                                BYTE_W'(i_out_mon.chunk_end));
                    check_field("string_end", BYTE_W'(want.string_end),
                                BYTE_W'(i_out_mon.string_end));
                end
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= chunk_words_due.size();
    end

endmodule

[verif/string_split_by_separator_unit_tb.sv]
`timescale 1ns / 1ps
// Splitter testbench top: drives strings and register writes, then gives the verdict.
module string_split_by_separator_unit_tb;
    import ssep_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RST_CYCLES      = 6;
    // time through the unit, up to eight flush words, and some slack
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 23;
    localparam int HEAVY_PCT       = 61;
    localparam int MIXED_PCT       = 35;
    localparam int NOISE_PCT       = 8;
    localparam int WATCHDOG_NS     = 2_000_000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ssep_in_if  in_ch();
    ssep_out_if out_ch();
    ssep_cfg_if cfg_ch();

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_off_req   = 0;
    int               fail_cnt;
    int               pending_cnt;
    logic [SEP_W-1:0] cur_sep;
    logic [LEN_W-1:0] cur_len;

    always #(CLK_HALF) i_clk = ~i_clk;

    string_split_by_separator_unit dut (
        .i_clk,
        .i_rst_n,
        .i_in  (in_ch),
        .o_out (out_ch),
        .i_cfg (cfg_ch)
    );

    string_split_by_separator_unit_chk chk (
        .i_clk,
        .i_rst_n,
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .i_cfg_mon  (cfg_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    // Pick how often each side idles; the receiver picks its share up at the next edge
    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = HEAVY_PCT;
                recv_stall_pct <= 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct <= HEAVY_PCT;
            end
            default: begin
                send_idle_pct  = MIXED_PCT;
                recv_stall_pct <= MIXED_PCT;
            end
        endcase
    endtask

    // Offer one word and hold it until the unit takes it. Valid stays high into the
    // next word unless an idle gap is drawn, so it is never lowered and raised in one step.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic has, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.has_byte <= has;
        in_ch.is_last  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // One register write, with valid dropped afterwards
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait until every expected word has come back, then let the unit settle
    // (a word that causes nothing may still be inside it)
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Build one string out of whole separators, broken separator prefixes and loose bytes,
    // half from the separator, then send it with the odd ignored word in between.
    task automatic send_random_string(output int words);
        logic [BYTE_W-1:0] str_q [$];
        int                eff;
        int                pieces;
        int                cut;
        int                roll;
        logic              bare_end;
        eff = (cur_len == '0) ? 1 :
              (cur_len > LEN_W'(MAX_SEP_BYTES)) ? MAX_SEP_BYTES : int'(cur_len);
        pieces = $urandom_range(0, 6);
        for (int i = 0; i < pieces; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                for (int k = 0; k < eff; k++) str_q.push_back(cur_sep[BYTE_W*k +: BYTE_W]);
            end else if (roll < 60) begin
                // separator cut short, then whatever byte comes along
                cut = (eff > 1) ? $urandom_range(1, eff - 1) : 0;
                for (int k = 0; k < cut; k++) str_q.push_back(cur_sep[BYTE_W*k +: BYTE_W]);
                str_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        cut = $urandom_range(0, eff - 1);
                        str_q.push_back(cur_sep[BYTE_W*cut +: BYTE_W]);
                    end else begin
                        str_q.push_back(BYTE_W'($urandom_range(0, 255)));
                    end
                end
            end
        end
        // close either on the last byte or with a word that carries no byte
        bare_end = (str_q.size() == 0) || ($urandom_range(0, 4) == 0);
        words = 0;
        foreach (str_q[i]) begin
            if ($urandom_range(0, 99) < NOISE_PCT) begin
                send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_word(str_q[i], 1'b1, !bare_end && (i == str_q.size() - 1));
            words++;
        end
        if (bare_end) begin
            send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            words++;
        end
    endtask

    // Receiver: stall at random, or hold off for a long stretch when asked
    initial begin : receiver
        int hold_left;
        int seen_req;
        hold_left    = 0;
        seen_req     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req != seen_req) begin
                seen_req  = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin : stimulus
        int               words;
        int               n;
        logic [SEP_W-1:0] sep_val;
        logic [LEN_W-1:0] len_val;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        in_ch.has_byte = 1'b0;
        in_ch.is_last  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_SEP_BYTES;
        cfg_ch.data    = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset separator is one zero byte: both byte extremes, a trailing separator,
        // an empty string, an ignored word and a string that is only the separator
        set_idle(IDLE_NONE);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h5a, 1'b0, 1'b1);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        wait_idle();

        // Length above the maximum clamps to eight: a full match, then seven held bytes
        // and a mismatching last byte, which gives the longest burst of result words
        write_reg(CFG_SEP_BYTES, 64'h4847_4645_4443_4241);
        write_reg(CFG_SEP_LEN, CFG_DATA_W'(15));
        for (int i = 0; i < 8; i++) send_word(BYTE_W'(8'h41 + i), 1'b1, 1'b0);
        for (int i = 0; i < 7; i++) send_word(BYTE_W'(8'h41 + i), 1'b1, 1'b0);
        send_word(8'h5a, 1'b1, 1'b1);
        wait_idle();

        // Zero length counts as one
        write_reg(CFG_SEP_BYTES, 64'h2c);
        write_reg(CFG_SEP_LEN, CFG_DATA_W'(0));
        send_word(8'h2c, 1'b1, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h2c, 1'b1, 1'b1);

        // Random strings, one separator setting and one idle pattern per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            sep_val = {$urandom, $urandom};
            case (p)
                0:       len_val = LEN_W'(1);
                1:       len_val = LEN_W'(MAX_SEP_BYTES);
                2:       len_val = LEN_W'(2);
                3:       len_val = LEN_W'($urandom_range(3, 7));
                4:       len_val = '0;
                5:       len_val = '1;
                6: begin
                    // zero bytes inside the separator
                    sep_val = sep_val & 64'hffff_0000_00ff_0000;
                    len_val = LEN_W'($urandom_range(4, 8));
                end
                default: len_val = LEN_W'($urandom_range(1, 15));
            endcase
            cur_sep = sep_val;
            cur_len = len_val;
            write_reg(CFG_SEP_BYTES, sep_val);
            write_reg(CFG_SEP_LEN, CFG_DATA_W'(len_val));
            set_idle(t_idle_mode'(p % 4));
            // first phase: hold the receiver off while words keep coming, so the
            // queue fills and the input stalls
            if (p == 0) hold_off_req <= hold_off_req + 1;
            words = 0;
            while (words < WORDS_PER_PHASE) begin
                send_random_string(n);
                words += n;
            end
        end

        wait_idle();
        @(negedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
